// File: src/first_fit_block_allocator_unit_macros.svh
// Assertion macros for the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Implication checked on every rising clock edge, disabled while reset is held.
`define FFBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every rising clock edge.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ffba_pkg.sv
// Package for the first-fit block allocator: shared types and constants.
package ffba_pkg;

  localparam int unsigned PoolBytesDef   = 2048;
  localparam int unsigned AlignBytesDef  = 8;
  localparam int unsigned HeaderBytesDef = 2;

  localparam int unsigned AddrW  = 11;
  localparam int unsigned BytesW = 12;
  localparam int unsigned StatW  = 2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_NO_FIT   = 2'd1;
  localparam logic [StatW-1:0] ST_BAD_FREE = 2'd2;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLEAR,
    CMD_READ,
    CMD_ALLOC_STEP,
    CMD_SPLIT,
    CMD_FREE_CHECK,
    CMD_MERGE_CUR,
    CMD_MERGE_NEXT,
    CMD_MERGE_CLEAR
  } cmd_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic found;
    logic split;
    logic walk_end;
    logic chk_bad;
    logic cur_used;
    logic nxt_free;
  } dp_status_t;

endpackage

// File: src/ffba_datapath.sv
// Datapath of the allocator: header memory, walk pointer and result registers.
module ffba_datapath import ffba_pkg::*; #(
  parameter int unsigned POOL_BYTES   = PoolBytesDef,
  parameter int unsigned ALIGN_BYTES  = AlignBytesDef,
  parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_e              cmd_i,
  input  logic              req_type_i,
  input  logic [BytesW-1:0] alloc_bytes_i,
  input  logic [AddrW-1:0]  free_addr_i,
  output dp_status_t        status_o,
  output logic [AddrW-1:0]  user_addr_o
);

  localparam int unsigned Granules = POOL_BYTES / ALIGN_BYTES;
  localparam int unsigned GW       = (Granules > 1) ? $clog2(Granules) : 1;
  localparam int unsigned SW       = $clog2(Granules + 1);
  // Wide enough for need, which may exceed the pool.
  localparam int unsigned NW       = BytesW + 1;
  localparam int unsigned AlignSh  = $clog2(ALIGN_BYTES);
  localparam int unsigned MaxOff   = POOL_BYTES - 1 - HEADER_BYTES;

  // Entry: start flag, used flag, size in granules.
  typedef struct packed {
    logic          start;
    logic          used;
    logic [SW-1:0] size;
  } hdr_t;

  hdr_t             mem_q [Granules];
  hdr_t             rd_q;
  logic [SW-1:0]    g_q, g_d;
  logic [NW-1:0]    need_q;
  logic [SW-1:0]    left_q;
  logic [SW-1:0]    cspan_q;
  logic [SW-1:0]    nx_q;
  logic             cur_start_q;
  logic             bad_q;
  logic [AddrW-1:0] user_q;

  logic           we;
  logic [GW-1:0]  wa;
  hdr_t           wd;
  logic [GW-1:0]  ra;

  logic [SW-1:0]  span, nx, left, nspan;
  logic [SW:0]    nx_w;
  logic           fit, split, walk_end, bad;
  logic [NW-1:0]  bytes_sum;
  logic [AddrW:0] off;
  logic [AddrW:0] fg_w;

  // Span of the block in rd_q, taken as starting at g_q.
  always_comb begin
    span = rd_q.size;
    if (span == '0) span = SW'(1);
    if ({1'b0, span} > (SW+1)'(Granules) - {1'b0, g_q}) span = SW'(Granules) - g_q;
  end

  // Span of the successor block, which the merge walk reads at nx_q.
  always_comb begin
    nspan = rd_q.size;
    if (nspan == '0) nspan = SW'(1);
    if ({1'b0, nspan} > (SW+1)'(Granules) - {1'b0, nx_q}) nspan = SW'(Granules) - nx_q;
  end

  assign nx_w      = {1'b0, g_q} + {1'b0, span};
  assign nx        = nx_w[SW-1:0];
  assign walk_end  = nx_w >= (SW+1)'(Granules);
  assign fit       = !rd_q.used && (need_q <= NW'(span));
  assign left      = span - SW'(need_q);
  assign split     = (32'(left) << AlignSh) > 32'(HEADER_BYTES);
  assign bytes_sum = NW'(alloc_bytes_i) + NW'(HEADER_BYTES) + NW'(ALIGN_BYTES - 1);
  assign off       = {1'b0, free_addr_i} - (AddrW+1)'(HEADER_BYTES);
  assign fg_w      = off >> AlignSh;
  assign bad       = (free_addr_i < AddrW'(HEADER_BYTES)) || (32'(off) > MaxOff) ||
                     ((off & (AddrW+1)'(ALIGN_BYTES - 1)) != '0) ||
                     (32'(fg_w) >= Granules);

  always_comb begin
    we  = 1'b0;
    wa  = g_q[GW-1:0];
    wd  = rd_q;
    g_d = g_q;
    ra  = g_q[GW-1:0];
    unique case (cmd_i)
      CMD_NONE: ;
      CMD_READ: ;
      CMD_CLEAR: begin
        we = 1'b1;
        wd = '0;
        if (g_q == '0) begin
          wd.start = 1'b1;
          wd.size  = SW'(Granules);
        end
        g_d = g_q + SW'(1);
      end
      CMD_LOAD: begin
        if (req_type_i == REQ_FREE) begin
          g_d = SW'(fg_w);
          ra  = fg_w[GW-1:0];
        end else begin
          g_d = '0;
          ra  = '0;
        end
      end
      CMD_ALLOC_STEP: begin
        if (fit) begin
          we = 1'b1;
          wd.used = 1'b1;
          if (split) wd.size = SW'(need_q);
        end else begin
          g_d = nx;
          ra  = nx[GW-1:0];
        end
      end
      CMD_SPLIT: begin
        we = 1'b1;
        wa = g_q[GW-1:0] + GW'(need_q);
        wd = '{start: 1'b1, used: 1'b0, size: left_q};
      end
      CMD_FREE_CHECK: begin
        we = 1'b1;
        wd.used = 1'b0;
        g_d = '0;
      end
      CMD_MERGE_CUR: begin
        // Fetch the successor; a used block is simply stepped over.
        ra = nx[GW-1:0];
        if (rd_q.used) g_d = nx;
      end
      CMD_MERGE_NEXT: begin
        if (rd_q.start && !rd_q.used) begin
          we = 1'b1;
          wd = '{start: cur_start_q, used: 1'b0, size: cspan_q + nspan};
        end else begin
          g_d = nx_q;
          ra  = nx_q[GW-1:0];
        end
      end
      CMD_MERGE_CLEAR: begin
        we = 1'b1;
        wa = nx_q[GW-1:0];
        wd = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q         <= '0;
      need_q      <= '0;
      left_q      <= '0;
      cspan_q     <= '0;
      nx_q        <= '0;
      cur_start_q <= 1'b0;
      bad_q       <= 1'b0;
      user_q      <= '0;
    end else begin
      g_q <= g_d;
      if (cmd_i == CMD_LOAD) begin
        need_q <= bytes_sum >> AlignSh;
        bad_q  <= bad;
        user_q <= '0;
      end
      if (cmd_i == CMD_ALLOC_STEP && fit) begin
        left_q <= left;
        user_q <= AddrW'((32'(g_q) << AlignSh) + HEADER_BYTES);
      end
      if (cmd_i == CMD_MERGE_CUR) begin
        cspan_q     <= span;
        nx_q        <= nx;
        cur_start_q <= rd_q.start;
      end
    end
  end

  assign status_o.clear_done = (g_q == SW'(Granules - 1));
  assign status_o.found      = fit;
  assign status_o.split      = split;
  assign status_o.walk_end   = walk_end;
  assign status_o.chk_bad    = bad_q || !rd_q.start;
  assign status_o.cur_used   = rd_q.used;
  assign status_o.nxt_free   = rd_q.start && !rd_q.used;
  assign user_addr_o         = user_q;

endmodule

// File: src/ffba_ctrl.sv
// Controller state machine of the allocator.
module ffba_ctrl import ffba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             req_type_i,
  input  dp_status_t       dp_i,
  output cmd_e             cmd_o,
  output logic             busy_o,
  output logic             done_o,
  output logic [StatW-1:0] status_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ALLOC, S_SPLIT, S_CHK, S_MRD, S_MCUR, S_MNXT, S_MCLR, S_OUT
  } state_e;

  state_e           state_q;
  logic [StatW-1:0] st_q;
  logic             done_q;

  always_comb begin
    unique case (state_q)
      S_CLEAR: cmd_o = CMD_CLEAR;
      S_IDLE:  cmd_o = (start_i) ? CMD_LOAD : CMD_NONE;
      S_ALLOC: cmd_o = CMD_ALLOC_STEP;
      S_SPLIT: cmd_o = CMD_SPLIT;
      S_CHK:   cmd_o = (dp_i.chk_bad) ? CMD_NONE : CMD_FREE_CHECK;
      S_MRD:   cmd_o = CMD_READ;
      S_MCUR:  cmd_o = CMD_MERGE_CUR;
      S_MNXT:  cmd_o = CMD_MERGE_NEXT;
      S_MCLR:  cmd_o = CMD_MERGE_CLEAR;
      default: cmd_o = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      st_q    <= ST_OK;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: if (dp_i.clear_done) state_q <= S_IDLE;
        S_IDLE: if (start_i) begin
          st_q    <= ST_OK;
          state_q <= (req_type_i == REQ_FREE) ? S_CHK : S_ALLOC;
        end
        S_ALLOC: begin
          if (dp_i.found) state_q <= (dp_i.split) ? S_SPLIT : S_OUT;
          else if (dp_i.walk_end) begin
            st_q    <= ST_NO_FIT;
            state_q <= S_OUT;
          end
        end
        S_SPLIT: state_q <= S_OUT;
        S_CHK: begin
          if (dp_i.chk_bad) begin
            st_q    <= ST_BAD_FREE;
            state_q <= S_OUT;
          end else state_q <= S_MRD;
        end
        S_MRD: state_q <= S_MCUR;
        S_MCUR: begin
          if (dp_i.walk_end) state_q <= S_OUT;
          else if (!dp_i.cur_used) state_q <= S_MNXT;
        end
        S_MNXT: state_q <= (dp_i.nxt_free) ? S_MCLR : S_MCUR;
        S_MCLR: state_q <= S_MCUR;
        S_OUT: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = st_q;

endmodule

// File: src/first_fit_block_allocator_unit.sv
// Top level of the first-fit block allocator.
// One request word is taken when start is high and busy is low, and requests are
// handled one at a time: busy stays high from acceptance until the result cycle.
// The result appears for exactly one cycle with done_o high and cannot be held
// off. After reset a clearing pass writes every entry of the header memory
// while busy stays high. An allocate visits one block per cycle, then writes
// the split remainder in a split step if one is needed, and finishes in an
// output step. A free checks the address and header, ending there if either
// is bad, then walks the whole pool once to merge free neighbours: a used
// block is stepped over, and a free block is merged with a free successor.
// ALIGN_BYTES must be a power of two.
`include "first_fit_block_allocator_unit_macros.svh"
module first_fit_block_allocator_unit import ffba_pkg::*; #(
  parameter int unsigned POOL_BYTES   = PoolBytesDef,
  parameter int unsigned ALIGN_BYTES  = AlignBytesDef,
  parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              req_type_i,
  input  logic [BytesW-1:0] alloc_bytes_i,
  input  logic [AddrW-1:0]  free_addr_i,
  output logic              done_o,
  output logic [AddrW-1:0]  user_addr_o,
  output logic [StatW-1:0]  status_o
);

  cmd_e       cmd;
  dp_status_t dps;

  ffba_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .req_type_i, .dp_i(dps),
    .cmd_o(cmd), .busy_o(busy), .done_o, .status_o
  );

  // The datapath captures everything it needs from the word when it is accepted.
  ffba_datapath #(
    .POOL_BYTES(POOL_BYTES), .ALIGN_BYTES(ALIGN_BYTES), .HEADER_BYTES(HEADER_BYTES)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .req_type_i, .alloc_bytes_i, .free_addr_i,
    .status_o(dps), .user_addr_o
  );

  `FFBA_ASSERT_NEXT(a_done_one, clk_i, rst_ni, done_o, !done_o, "done held two cycles")
  `FFBA_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy, "done while busy")
  `FFBA_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, done_o && status_o != ST_OK,
    user_addr_o == '0, "failed result carries an address")

endmodule

// File: dv/first_fit_block_allocator_unit_test.sv
// Testbench for the first-fit block allocator: directed table, then random requests.
`timescale 1ns / 1ps
module first_fit_block_allocator_unit_test;
  import ffba_pkg::*;

  localparam int unsigned Granules = PoolBytesDef / AlignBytesDef;
  localparam int unsigned NumRandom = 1030;
  localparam longint unsigned CycleLimit = 4_000_000;

  typedef struct packed {
    logic             kind;
    logic [BytesW-1:0] bytes;
    logic [AddrW-1:0]  addr;
    logic             has_exp;
    logic [AddrW-1:0]  exp_addr;
    logic [StatW-1:0]  exp_status;
  } stim_row_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [StatW-1:0] status;
  } alloc_result_t;

  logic clk;
  logic rst_n;
  logic start_r;
  logic busy_w;
  logic kind_r;
  logic [BytesW-1:0] bytes_r;
  logic [AddrW-1:0] addr_r;
  logic done_w;
  logic [AddrW-1:0] user_addr_w;
  logic [StatW-1:0] status_w;

  // Shadow copy of the block headers.
  bit          hdr_start [Granules];
  bit          hdr_used  [Granules];
  int unsigned hdr_size  [Granules];

  alloc_result_t pending_results[$];
  int unsigned   live_addrs[$];
  int unsigned   error_count;
  int unsigned   word_count;
  int unsigned   ok_count, nofit_count, badfree_count;
  longint unsigned cycle_count;

  first_fit_block_allocator_unit u_top (
    .clk_i(clk), .rst_ni(rst_n), .start(start_r), .busy(busy_w),
    .req_type_i(kind_r), .alloc_bytes_i(bytes_r), .free_addr_i(addr_r),
    .done_o(done_w), .user_addr_o(user_addr_w), .status_o(status_w)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  function automatic int unsigned block_span(int unsigned g);
    int unsigned s;
    s = hdr_size[g];
    if (s == 0) s = 1;
    if (s > Granules - g) s = Granules - g;
    return s;
  endfunction

  function automatic void heap_reset();
    foreach (hdr_start[i]) begin
      hdr_start[i] = 0; hdr_used[i] = 0; hdr_size[i] = 0;
    end
    hdr_start[0] = 1;
    hdr_size[0] = Granules;
  endfunction

  function automatic void coalesce_pool();
    int unsigned g, s, nx;
    g = 0;
    while (g < Granules) begin
      s = block_span(g);
      nx = g + s;
      if (!hdr_used[g] && nx < Granules && hdr_start[nx] && !hdr_used[nx]) begin
        hdr_size[g] = s + block_span(nx);
        hdr_start[nx] = 0; hdr_used[nx] = 0; hdr_size[nx] = 0;
      end else begin
        g = nx;
      end
    end
  endfunction

  function automatic alloc_result_t predict_heap(logic kind, logic [BytesW-1:0] bytes,
                                                 logic [AddrW-1:0] addr);
    alloc_result_t r;
    int unsigned need, g, s, left, off;
    r.addr = '0;
    r.status = ST_OK;
    if (kind == REQ_ALLOC) begin
      need = (bytes + HeaderBytesDef + AlignBytesDef - 1) / AlignBytesDef;
      r.status = ST_NO_FIT;
      g = 0;
      while (g < Granules) begin
        s = block_span(g);
        if (!hdr_used[g] && need <= s) begin
          left = s - need;
          if (left * AlignBytesDef > HeaderBytesDef) begin
            hdr_start[g + need] = 1; hdr_used[g + need] = 0; hdr_size[g + need] = left;
            hdr_size[g] = need;
          end
          hdr_used[g] = 1;
          r.addr = AddrW'(g * AlignBytesDef + HeaderBytesDef);
          r.status = ST_OK;
          break;
        end
        g += s;
      end
    end else begin
      r.status = ST_BAD_FREE;
      if (addr >= HeaderBytesDef) begin
        off = addr - HeaderBytesDef;
        if (off <= PoolBytesDef - 1 - HeaderBytesDef && off % AlignBytesDef == 0 &&
            off / AlignBytesDef < Granules && hdr_start[off / AlignBytesDef]) begin
          hdr_used[off / AlignBytesDef] = 0;
          coalesce_pool();
          r.status = ST_OK;
        end
      end
    end
    return r;
  endfunction

  // Drives one word, waits for acceptance, and records the expected result.
  // Start stays high after acceptance until the next word or gap changes it.
  task automatic issue_word(stim_row_t row);
    alloc_result_t exp_r;
    int unsigned gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start_r <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start_r <= 1'b1;
    kind_r  <= row.kind;
    bytes_r <= row.bytes;
    addr_r  <= row.addr;
    do @(posedge clk); while (busy_w);
    exp_r = predict_heap(row.kind, row.bytes, row.addr);
    if (row.has_exp && (exp_r.addr != row.exp_addr || exp_r.status != row.exp_status)) begin
      $error("table row disagrees: addr exp %0d got %0d, status exp %0d got %0d",
             row.exp_addr, exp_r.addr, row.exp_status, exp_r.status);
      error_count++;
    end
    if (row.kind == REQ_ALLOC && exp_r.status == ST_OK) live_addrs.push_back(exp_r.addr);
    pending_results.push_back(exp_r);
    word_count++;
  endtask

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n && done_w) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (user_addr_w != exp_r.addr) begin
          $error("user_addr: expected %0d, actual %0d", exp_r.addr, user_addr_w);
          error_count++;
        end
        if (status_w != exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, status_w);
          error_count++;
        end
        case (exp_r.status)
          ST_OK:       ok_count++;
          ST_NO_FIT:   nofit_count++;
          default:     badfree_count++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  stim_row_t directed[] = '{
    // After reset the first allocation lands just behind granule 0's header.
    '{REQ_ALLOC, 12'd0,    11'd0,    1'b1, 11'd2,  ST_OK},
    '{REQ_ALLOC, 12'd6,    11'd0,    1'b1, 11'd10, ST_OK},
    '{REQ_ALLOC, 12'd7,    11'd0,    1'b1, 11'd18, ST_OK},
    '{REQ_ALLOC, 12'd2048, 11'd0,    1'b1, 11'd0,  ST_NO_FIT},
    '{REQ_ALLOC, 12'd4095, 11'd0,    1'b1, 11'd0,  ST_NO_FIT},
    '{REQ_FREE,  12'd0,    11'd0,    1'b1, 11'd0,  ST_BAD_FREE},
    '{REQ_FREE,  12'd0,    11'd1,    1'b1, 11'd0,  ST_BAD_FREE},
    '{REQ_FREE,  12'd0,    11'd2047, 1'b1, 11'd0,  ST_BAD_FREE},
    '{REQ_FREE,  12'd0,    11'd5,    1'b1, 11'd0,  ST_BAD_FREE},
    '{REQ_FREE,  12'd0,    11'd10,   1'b1, 11'd0,  ST_OK},
    '{REQ_FREE,  12'd0,    11'd10,   1'b1, 11'd0,  ST_OK},
    '{REQ_FREE,  12'd0,    11'd50,   1'b1, 11'd0,  ST_BAD_FREE},
    '{REQ_FREE,  12'd0,    11'd2,    1'b1, 11'd0,  ST_OK},
    '{REQ_FREE,  12'd0,    11'd18,   1'b1, 11'd0,  ST_OK},
    '{REQ_ALLOC, 12'd2046, 11'd0,    1'b1, 11'd2,  ST_OK},
    '{REQ_ALLOC, 12'd0,    11'd0,    1'b1, 11'd0,  ST_NO_FIT},
    '{REQ_FREE,  12'd0,    11'd2,    1'b1, 11'd0,  ST_OK},
    '{REQ_ALLOC, 12'd1000, 11'd0,    1'b0, 11'd0,  ST_OK},
    '{REQ_ALLOC, 12'd1000, 11'd0,    1'b0, 11'd0,  ST_OK},
    '{REQ_ALLOC, 12'd100,  11'd1234, 1'b0, 11'd0,  ST_OK},
    '{REQ_FREE,  12'hFFF,  11'd1010, 1'b0, 11'd0,  ST_OK},
    '{REQ_FREE,  12'd0,    11'd2042, 1'b1, 11'd0,  ST_BAD_FREE},
    '{REQ_FREE,  12'd0,    11'd2,    1'b1, 11'd0,  ST_OK}
  };

  initial begin
    stim_row_t row;
    int unsigned pick, wait_cycles;
    error_count = 0; word_count = 0; cycle_count = 0;
    ok_count = 0; nofit_count = 0; badfree_count = 0;
    start_r = 1'b0; kind_r = REQ_ALLOC; bytes_r = '0; addr_r = '0;
    rst_n = 1'b0;
    heap_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      issue_word(directed[i]);
      if (directed[i].addr == 11'd2 && directed[i].kind == REQ_FREE)
        live_addrs = {};
    end

    for (int n = 0; n < NumRandom; n++) begin
      row = '0;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // Mostly small words, with a few large and out-of-range ones.
        row.kind = REQ_ALLOC;
        case ($urandom_range(0, 9))
          0:       row.bytes = BytesW'($urandom);
          1:       row.bytes = BytesW'($urandom_range(256, 2048));
          default: row.bytes = BytesW'($urandom_range(0, 120));
        endcase
        row.addr = AddrW'($urandom);
      end else begin
        row.kind  = REQ_FREE;
        row.bytes = BytesW'($urandom);
        if (pick < 85 && live_addrs.size() > 0) begin
          wait_cycles = $urandom_range(0, live_addrs.size() - 1);
          row.addr = AddrW'(live_addrs[wait_cycles]);
          live_addrs.delete(wait_cycles);
        end else if (pick < 92) begin
          row.addr = AddrW'($urandom_range(0, 255) * AlignBytesDef + HeaderBytesDef);
        end else begin
          row.addr = AddrW'($urandom);
        end
      end
      issue_word(row);
    end
    start_r <= 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    $display("Ran %0d request words: %0d ok, %0d without a fitting block, %0d bad frees.",
             word_count, ok_count, nofit_count, badfree_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
